[rtl/assert_macros.svh]
// Assertion helpers; the enclosing scope provides i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TCQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tcq: same-cycle check failed");

// Next-cycle implication.
`define TCQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tcq: next-cycle check failed");

`endif

[rtl/tcq_pkg.sv]
package tcq_pkg;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_CLEAR  = 2'd1,
        FN_POLL   = 2'd2,
        FN_NOP    = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_WR,
        ST_POLL_CHK,
        ST_DROP_RD,
        ST_DROP_WR,
        ST_DROP_END,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        RA_HEAD,
        RA_IDX_DEC,
        RA_IDX_INC
    } t_raddr_sel;

    typedef struct packed {
        logic [7:0]  code;
        logic [31:0] value;
        logic [31:0] due;
        logic [31:0] period;
    } t_entry;

    typedef struct packed {
        logic        accepted;
        logic        due_valid;
        logic [7:0]  due_cmd;
        logic [31:0] due_value;
        logic [4:0]  queue_count;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic       cap;
        logic       clear;
        logic       ins_start;
        logic       take_head;
        logic       shift_dn;
        logic       place;
        logic       shift_up;
        logic       drop_end;
        logic       load_out;
        t_raddr_sel raddr_sel;
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        t_func func;
        logic  full;
        logic  cnt_zero;
        logic  cnt_one;
        logic  idx_one;
        logic  idx_end;
        logic  less;
        logic  due;
        logic  again;
        logic  out_free;
    } t_stat;

endpackage

[rtl/tcq_if.sv]
interface tcq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  cmd_code;
    logic [31:0] cmd_value;
    logic [31:0] due_time;
    logic [31:0] repeat_period;
    logic [31:0] now_time;

    modport source (
        output valid, func, cmd_code, cmd_value, due_time, repeat_period, now_time,
        input  ready
    );
    modport sink (
        input  valid, func, cmd_code, cmd_value, due_time, repeat_period, now_time,
        output ready
    );
endinterface

interface tcq_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        due_valid;
    logic [7:0]  due_cmd;
    logic [31:0] due_value;
    logic [4:0]  queue_count;

    modport source (
        output valid, accepted, due_valid, due_cmd, due_value, queue_count,
        input  ready
    );
    modport sink (
        input  valid, accepted, due_valid, due_cmd, due_value, queue_count,
        output ready
    );
endinterface

[rtl/tcq_ram.sv]
module tcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/tcq_ctrl.sv]
module tcq_ctrl
    import tcq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_ctl  o_ctl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                case (i_stat.func)
                    FN_INSERT: begin
                        if (i_stat.full)          n_state = ST_DONE;
                        else if (i_stat.cnt_zero) n_state = ST_INS_WR;
                        else                      n_state = ST_INS_RD;
                    end
                    FN_POLL: begin
                        n_state = i_stat.cnt_zero ? ST_DONE : ST_POLL_CHK;
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_INS_RD:  n_state = ST_INS_CMP;
            ST_INS_CMP: begin
                if (i_stat.less && !i_stat.idx_one) n_state = ST_INS_RD;
                else                                n_state = ST_INS_WR;
            end
            ST_INS_WR:  n_state = ST_DONE;
            ST_POLL_CHK: begin
                if (!i_stat.due)         n_state = ST_DONE;
                else if (i_stat.cnt_one) n_state = ST_DROP_END;
                else                     n_state = ST_DROP_RD;
            end
            ST_DROP_RD: n_state = ST_DROP_WR;
            ST_DROP_WR: n_state = i_stat.idx_end ? ST_DROP_END : ST_DROP_RD;
            ST_DROP_END: begin
                if (!i_stat.again)       n_state = ST_DONE;
                else if (i_stat.cnt_one) n_state = ST_INS_WR;
                else                     n_state = ST_INS_RD;
            end
            ST_DONE: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl           = '0;
        o_ctl.raddr_sel = RA_HEAD;
        o_in_ready      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.cap  = i_in_valid;
            end
            ST_DECODE: begin
                case (i_stat.func)
                    FN_INSERT: o_ctl.ins_start = !i_stat.full;
                    FN_CLEAR:  o_ctl.clear     = 1'b1;
                    default:   o_ctl.raddr_sel = RA_HEAD;
                endcase
            end
            ST_INS_RD:   o_ctl.raddr_sel = RA_IDX_DEC;
            ST_INS_CMP:  o_ctl.shift_dn  = i_stat.less;
            ST_INS_WR:   o_ctl.place     = 1'b1;
            ST_POLL_CHK: o_ctl.take_head = i_stat.due;
            ST_DROP_RD:  o_ctl.raddr_sel = RA_IDX_INC;
            ST_DROP_WR:  o_ctl.shift_up  = 1'b1;
            ST_DROP_END: o_ctl.drop_end  = 1'b1;
            ST_DONE:     o_ctl.load_out  = i_stat.out_free;
            default:     o_ctl.raddr_sel = RA_HEAD;
        endcase
    end

endmodule

[rtl/tcq_dp.sv]
module tcq_dp
    import tcq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_ctl    i_ctl,
    output t_stat   o_stat,
    input  t_func   i_func,
    input  t_entry  i_ent,
    input  logic [31:0] i_now,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_result
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_func       r_func;
    logic [31:0] r_now;
    t_entry      r_ent,   n_ent;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx,   n_idx;
    logic        r_again, n_again;
    logic        r_acc,   n_acc;
    logic        r_dv,    n_dv;
    logic [7:0]  r_dcode, n_dcode;
    logic [31:0] r_dvalue, n_dvalue;
    logic        r_o_valid, n_o_valid;
    t_result     r_result,  n_result;

    logic [CW-1:0] w_ra_full;
    logic [AW-1:0] w_raddr;
    logic          w_we;
    t_entry        w_wdata;
    t_entry        w_rdata;

    always_comb begin
        case (i_ctl.raddr_sel)
            RA_IDX_DEC: w_ra_full = r_idx - 1'b1;
            RA_IDX_INC: w_ra_full = r_idx + 1'b1;
            default:    w_ra_full = '0;
        endcase
    end

    assign w_raddr = w_ra_full[AW-1:0];
    assign w_we    = i_ctl.shift_dn | i_ctl.place | i_ctl.shift_up;
    assign w_wdata = i_ctl.place ? r_ent : w_rdata;

    tcq_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_idx[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        o_stat.func     = r_func;
        o_stat.full     = (r_count == CW'(QUEUE_DEPTH));
        o_stat.cnt_zero = (r_count == '0);
        o_stat.cnt_one  = (r_count == CW'(1));
        o_stat.idx_one  = (r_idx == CW'(1));
        o_stat.idx_end  = ((r_idx + 1'b1) == (r_count - 1'b1));
        o_stat.less     = (r_ent.due < w_rdata.due);
        o_stat.due      = (r_now >= w_rdata.due);
        o_stat.again    = r_again;
        o_stat.out_free = !r_o_valid || i_out_ready;
    end

    always_comb begin
        n_ent     = r_ent;
        n_count   = r_count;
        n_idx     = r_idx;
        n_again   = r_again;
        n_acc     = r_acc;
        n_dv      = r_dv;
        n_dcode   = r_dcode;
        n_dvalue  = r_dvalue;
        n_o_valid = r_o_valid;
        n_result  = r_result;

        if (i_ctl.cap) begin
            n_ent    = i_ent;
            n_acc    = 1'b0;
            n_dv     = 1'b0;
            n_dcode  = '0;
            n_dvalue = '0;
            n_again  = 1'b0;
        end
        if (i_ctl.clear) begin
            n_count = '0;
            n_acc   = 1'b1;
        end
        if (i_ctl.ins_start) begin
            n_idx = r_count;
            n_acc = 1'b1;
        end
        if (i_ctl.take_head) begin
            n_dv         = 1'b1;
            n_dcode      = w_rdata.code;
            n_dvalue     = w_rdata.value;
            n_ent        = w_rdata;
            n_ent.due    = w_rdata.due + w_rdata.period;
            n_again      = (w_rdata.period != '0) && (r_count != CW'(QUEUE_DEPTH));
            n_idx        = '0;
        end
        if (i_ctl.shift_dn) n_idx = r_idx - 1'b1;
        if (i_ctl.shift_up) n_idx = r_idx + 1'b1;
        if (i_ctl.place)    n_count = r_count + 1'b1;
        if (i_ctl.drop_end) begin
            n_count = r_count - 1'b1;
            n_idx   = r_count - 1'b1;
        end

        if (i_ctl.load_out) begin
            n_o_valid            = 1'b1;
            n_result.accepted    = r_acc;
            n_result.due_valid   = r_dv;
            n_result.due_cmd     = r_dcode;
            n_result.due_value   = r_dvalue;
            n_result.queue_count = 5'(r_count);
        end else if (i_out_ready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_idx     <= '0;
            r_again   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_again   <= n_again;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_func <= i_func;
            r_now  <= i_now;
        end
        r_ent    <= n_ent;
        r_acc    <= n_acc;
        r_dv     <= n_dv;
        r_dcode  <= n_dcode;
        r_dvalue <= n_dvalue;
        r_result <= n_result;
    end

    assign o_out_valid = r_o_valid;
    assign o_result    = r_result;

endmodule

[rtl/timed_command_queue_unit.sv]
// Timed command queue: up to QUEUE_DEPTH commands kept sorted by due time.
// Input channel i_in: func selects insert, clear, poll (now_time) or no-op;
// one beat in gives exactly one result beat on o_out (accepted, due_valid,
// due_cmd, due_value, queue_count after the item).
// Entries live in one RAM with a registered read port; each entry compared or
// moved takes a read state and then a compare or write state. Steps per item:
// clear, no-op, refused insert and poll on an empty queue go straight to the
// result; a poll whose head is not due checks the head only; an insert walks
// from the tail, moving each entry later than the new one down a place, and
// writes the new one behind the first that is not later; a poll that releases
// shifts every remaining entry up a place and, for a repeating command, unless
// the queue was full, puts the head back with its due time advanced by its
// period. One item is in work at a time; i_in.ready is high only between items.
// Reset clears the entry count and the control state; RAM contents are not
// cleared and need no clearing pass.
// A stalled o_out holds its beat in the output register; the next input beat
// can still be taken and worked on, and its result waits until that
// register frees up.
module timed_command_queue_unit
    import tcq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tcq_in_if.sink        i_in,
    tcq_out_if.source     o_out
);

    t_ctl    w_ctl;
    t_stat   w_stat;
    t_entry  w_ent;
    t_result w_result;
    logic    w_in_ready;
    logic    w_out_valid;

    assign w_ent.code   = i_in.cmd_code;
    assign w_ent.value  = i_in.cmd_value;
    assign w_ent.due    = i_in.due_time;
    assign w_ent.period = i_in.repeat_period;

    tcq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_ctl      (w_ctl)
    );

    tcq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .o_stat      (w_stat),
        .i_func      (t_func'(i_in.func)),
        .i_ent       (w_ent),
        .i_now       (i_in.now_time),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_result    (w_result)
    );

    assign i_in.ready        = w_in_ready;
    assign o_out.valid       = w_out_valid;
    assign o_out.accepted    = w_result.accepted;
    assign o_out.due_valid   = w_result.due_valid;
    assign o_out.due_cmd     = w_result.due_cmd;
    assign o_out.due_value   = w_result.due_value;
    assign o_out.queue_count = w_result.queue_count;

endmodule

[rtl/tcq_checker.sv]
`include "assert_macros.svh"

module tcq_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_accepted,
    input logic        i_due_valid,
    input logic [7:0]  i_due_cmd,
    input logic [31:0] i_due_value,
    input logic [4:0]  i_queue_count
);

    `TCQ_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    `TCQ_ASSERT_NXT(a_one_at_a_time, i_in_valid && i_in_ready, !i_in_ready)
    `TCQ_ASSERT_IMP(a_count_range, i_out_valid, 32'(i_queue_count) <= 32'(QUEUE_DEPTH))
    `TCQ_ASSERT_IMP(a_flags_excl, i_out_valid, !(i_accepted && i_due_valid))
    `TCQ_ASSERT_IMP(a_idle_zero, i_out_valid && !i_due_valid,
                    (i_due_cmd == 8'd0) && (i_due_value == 32'd0))

endmodule

bind timed_command_queue_unit tcq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_tcq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_accepted    (o_out.accepted),
    .i_due_valid   (o_out.due_valid),
    .i_due_cmd     (o_out.due_cmd),
    .i_due_value   (o_out.due_value),
    .i_queue_count (o_out.queue_count)
);
